@@ design/ppmfg_pkg.sv @@
`timescale 1ns / 1ps

package ppmfg_pkg;

    // Fixed field widths of the item and result channels.
    localparam int unsigned VALUE_W     = 16;
    localparam int unsigned CH_INDEX_W  = 3;
    localparam int unsigned SLOT_W      = 3;
    localparam int unsigned CFG_INDEX_W = 1;

    // Item kinds.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_WIDTH  = 1'b1;

    // Configuration reset values.
    localparam logic [VALUE_W-1:0] FRAME_LENGTH_RESET = 16'd46080;
    localparam logic [VALUE_W-1:0] PULSE_WIDTH_RESET  = 16'd691;

    // Channel write request from the item stage to the channel bank.
    typedef struct packed {
        logic                  en;
        logic [CH_INDEX_W-1:0] index;
        logic [VALUE_W-1:0]    value;
    } ch_wr_t;

    // One result item.
    typedef struct packed {
        logic              ppm_level;
        logic [SLOT_W-1:0] slot_index;
        logic              slot_start;
    } result_t;

endpackage

@@ design/ppmfg_item_if.sv @@
`timescale 1ns / 1ps

interface ppmfg_item_if;

    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [ppmfg_pkg::CH_INDEX_W-1:0]    channel_index;
    logic [ppmfg_pkg::VALUE_W-1:0]       channel_value;

    modport source (output valid, output kind, output channel_index, output channel_value,
                    input ready);
    modport sink   (input valid, input kind, input channel_index, input channel_value,
                    output ready);

endinterface

@@ design/ppmfg_result_if.sv @@
`timescale 1ns / 1ps

interface ppmfg_result_if;

    logic                            valid;
    logic                            ready;
    logic                            ppm_level;
    logic [ppmfg_pkg::SLOT_W-1:0]    slot_index;
    logic                            slot_start;

    modport source (output valid, output ppm_level, output slot_index, output slot_start,
                    input ready);
    modport sink   (input valid, input ppm_level, input slot_index, input slot_start,
                    output ready);

endinterface

@@ design/ppmfg_cfg_if.sv @@
`timescale 1ns / 1ps

interface ppmfg_cfg_if;

    logic                                 valid;
    logic                                 ready;
    logic [ppmfg_pkg::CFG_INDEX_W-1:0]    index;
    logic [ppmfg_pkg::VALUE_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

@@ design/ppm_frame_generator_unit.sv @@
`timescale 1ns / 1ps

// Latency: a result is presented in the cycle after its input transfer.
// Throughput: one item per cycle; the timers and the channel sum update in a single pass.
// A result waiting in the output register holds off the input until its transfer completes.
// Reset: channels, timers and slot counter clear; frame_length = 46080, pulse_width = 691.
// The first tick after reset starts slot 0.
module ppm_frame_generator_unit #(
    parameter int unsigned NUM_CHANNELS = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    ppmfg_item_if.sink             in_item,
    ppmfg_result_if.source         out_result,
    ppmfg_cfg_if.sink              cfg
);

    localparam int unsigned SC_W  = $clog2(NUM_CHANNELS + 1);
    localparam int unsigned SUM_W = ppmfg_pkg::VALUE_W + $clog2(NUM_CHANNELS + 1);

    logic [ppmfg_pkg::VALUE_W-1:0] frame_length_reg;
    logic [ppmfg_pkg::VALUE_W-1:0] pulse_width_reg;
    logic                          out_valid_reg;
    ppmfg_pkg::result_t            result_reg;
    ppmfg_pkg::result_t            result_next;
    ppmfg_pkg::ch_wr_t             ch_wr;
    logic [SC_W-1:0]               rd_slot;
    logic [ppmfg_pkg::VALUE_W-1:0] slot_value;
    logic [SUM_W-1:0]              ch_sum;
    logic                          accept;
    logic                          tick;

    // Input transfer is taken whenever the output register is free or being emptied.
    assign in_item.ready = !out_valid_reg || out_result.ready;
    assign accept        = in_item.valid && in_item.ready;
    assign tick          = accept && (in_item.kind == ppmfg_pkg::KIND_TICK);

    assign ch_wr.en    = accept && (in_item.kind == ppmfg_pkg::KIND_WRITE);
    assign ch_wr.index = in_item.channel_index;
    assign ch_wr.value = in_item.channel_value;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= ppmfg_pkg::FRAME_LENGTH_RESET;
            pulse_width_reg  <= ppmfg_pkg::PULSE_WIDTH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ppmfg_pkg::CFG_FRAME_LENGTH: frame_length_reg <= cfg.data;
                ppmfg_pkg::CFG_PULSE_WIDTH:  pulse_width_reg  <= cfg.data;
                default:                     ;
            endcase
        end
    end

    ppmfg_channel_bank #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SC_W         (SC_W),
        .SUM_W        (SUM_W)
    ) u_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (ch_wr),
        .rd_slot  (rd_slot),
        .rd_value (slot_value),
        .ch_sum   (ch_sum)
    );

    ppmfg_slot_timer #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SC_W         (SC_W),
        .SUM_W        (SUM_W)
    ) u_timer (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .frame_length (frame_length_reg),
        .pulse_width  (pulse_width_reg),
        .slot_value   (slot_value),
        .ch_sum       (ch_sum),
        .rd_slot      (rd_slot),
        .result       (result_next)
    );

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_result.valid      = out_valid_reg;
    assign out_result.ppm_level  = result_reg.ppm_level;
    assign out_result.slot_index = result_reg.slot_index;
    assign out_result.slot_start = result_reg.slot_start;

endmodule

@@ design/ppmfg_channel_bank.sv @@
`timescale 1ns / 1ps

module ppmfg_channel_bank #(
    parameter int unsigned NUM_CHANNELS = 6,
    parameter int unsigned SC_W         = 3,
    parameter int unsigned SUM_W        = 19
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ppmfg_pkg::ch_wr_t                wr,
    input  logic [SC_W-1:0]                  rd_slot,
    output logic [ppmfg_pkg::VALUE_W-1:0]    rd_value,
    output logic [SUM_W-1:0]                 ch_sum
);

    logic [ppmfg_pkg::VALUE_W-1:0] store_reg  [NUM_CHANNELS];
    logic [ppmfg_pkg::VALUE_W-1:0] store_next [NUM_CHANNELS];
    logic [ppmfg_pkg::VALUE_W-1:0] old_value;
    logic [SUM_W-1:0]              sum_reg;
    logic [SUM_W-1:0]              sum_next;
    logic                          wr_hit;

    // Decode the write, pick the value it replaces and keep the channel sum current.
    always_comb
    begin
        wr_hit    = wr.en && (int'(wr.index) < NUM_CHANNELS);
        old_value = '0;
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            store_next[k] = store_reg[k];
            if (int'(wr.index) == k)
            begin
                old_value = store_reg[k];
            end
            if (wr_hit && (int'(wr.index) == k))
            begin
                store_next[k] = wr.value;
            end
        end
        sum_next = sum_reg;
        if (wr_hit)
        begin
            sum_next = sum_reg - SUM_W'(old_value) + SUM_W'(wr.value);
        end
    end

    // Duration of the slot that begins next; the sync slot reads zero and is unused.
    always_comb
    begin
        rd_value = '0;
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            if (int'(rd_slot) == k)
            begin
                rd_value = store_reg[k];
            end
        end
    end

    assign ch_sum = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                store_reg[k] <= '0;
            end
            sum_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                store_reg[k] <= store_next[k];
            end
            sum_reg <= sum_next;
        end
    end

endmodule

@@ design/ppmfg_slot_timer.sv @@
`timescale 1ns / 1ps

module ppmfg_slot_timer #(
    parameter int unsigned NUM_CHANNELS = 6,
    parameter int unsigned SC_W         = 3,
    parameter int unsigned SUM_W        = 19
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick,
    input  logic [ppmfg_pkg::VALUE_W-1:0]    frame_length,
    input  logic [ppmfg_pkg::VALUE_W-1:0]    pulse_width,
    input  logic [ppmfg_pkg::VALUE_W-1:0]    slot_value,
    input  logic [SUM_W-1:0]                 ch_sum,
    output logic [SC_W-1:0]                  rd_slot,
    output ppmfg_pkg::result_t               result
);

    localparam logic [SC_W-1:0] SYNC_SLOT = SC_W'(NUM_CHANNELS);

    logic [SC_W-1:0]               sc_reg;
    logic [SC_W-1:0]               sc_next;
    logic [ppmfg_pkg::VALUE_W-1:0] sr_reg;
    logic [ppmfg_pkg::VALUE_W-1:0] sr_next;
    logic [ppmfg_pkg::VALUE_W-1:0] pr_reg;
    logic [ppmfg_pkg::VALUE_W-1:0] pr_next;
    logic [ppmfg_pkg::VALUE_W-1:0] sr_dec;
    logic [ppmfg_pkg::VALUE_W-1:0] pr_dec;
    logic [ppmfg_pkg::VALUE_W-1:0] sync_dur;
    logic [SUM_W:0]                sum_plus_pulse;
    logic [SC_W-1:0]               active_slot;
    logic                          started;

    // The sync slot fills the rest of the frame but never drops below one pulse.
    always_comb
    begin
        sum_plus_pulse = (SUM_W + 1)'(ch_sum) + (SUM_W + 1)'(pulse_width);
        if ((SUM_W + 1)'(frame_length) >= sum_plus_pulse)
        begin
            sync_dur = ppmfg_pkg::VALUE_W'((SUM_W + 1)'(frame_length) - (SUM_W + 1)'(ch_sum));
        end
        else
        begin
            sync_dur = pulse_width;
        end
    end

    // Count down both timers on a tick and start the next slot when the current one ends.
    always_comb
    begin
        sr_dec  = (sr_reg != '0) ? sr_reg - 1'b1 : '0;
        pr_dec  = (pr_reg != '0) ? pr_reg - 1'b1 : '0;
        sr_next = sr_reg;
        pr_next = pr_reg;
        sc_next = sc_reg;
        started = 1'b0;
        if (tick)
        begin
            sr_next = sr_dec;
            pr_next = pr_dec;
            if (sr_dec == '0)
            begin
                if (sc_reg != SYNC_SLOT)
                begin
                    sr_next = slot_value;
                    sc_next = sc_reg + 1'b1;
                end
                else
                begin
                    sr_next = sync_dur;
                    sc_next = '0;
                end
                pr_next = pulse_width;
                started = 1'b1;
            end
        end
    end

    // The slot being timed is the one before the next slot to begin.
    always_comb
    begin
        active_slot       = (sc_next == '0) ? SYNC_SLOT : sc_next - 1'b1;
        result.ppm_level  = (pr_next != '0);
        result.slot_index = ppmfg_pkg::SLOT_W'(active_slot);
        result.slot_start = started;
    end

    assign rd_slot = sc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg <= '0;
            sr_reg <= '0;
            pr_reg <= '0;
        end
        else
        begin
            sc_reg <= sc_next;
            sr_reg <= sr_next;
            pr_reg <= pr_next;
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import ppmfg_pkg::*;

    localparam int unsigned NUM_CH = 6;
    localparam int unsigned LONG_HOLD = 400;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned SETTLE_CYCLES = 4;

    // Tracks the expected pin level and slot of the frame generator and checks
    // every result transfer against it in order.
    class ppm_frame_predictor;
        logic [VALUE_W-1:0] frame_length;
        logic [VALUE_W-1:0] pulse_width;
        logic [VALUE_W-1:0] channel_ticks [NUM_CH];
        int unsigned        next_slot;
        logic [VALUE_W-1:0] slot_left;
        logic [VALUE_W-1:0] pulse_left;
        result_t            pin_states_due [$];
        int unsigned        results_seen;
        int unsigned        mismatches;

        function new();
            frame_length = FRAME_LENGTH_RESET;
            pulse_width = PULSE_WIDTH_RESET;
            foreach (channel_ticks[k])
            begin
                channel_ticks[k] = '0;
            end
            next_slot = 0;
            slot_left = '0;
            pulse_left = '0;
            results_seen = 0;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [VALUE_W-1:0] data);
            if (index == CFG_FRAME_LENGTH)
            begin
                frame_length = data;
            end
            else if (index == CFG_PULSE_WIDTH)
            begin
                pulse_width = data;
            end
        endfunction

        // The sync space fills the frame but never drops below one pulse.
        function logic [VALUE_W-1:0] sync_ticks();
            int unsigned total;
            total = 0;
            foreach (channel_ticks[k])
            begin
                total += channel_ticks[k];
            end
            if (frame_length >= total + pulse_width)
            begin
                return VALUE_W'(frame_length - total);
            end
            return pulse_width;
        endfunction

        // Advance the frame by one accepted item and queue the pin state it yields.
        function void apply_item(logic kind, logic [CH_INDEX_W-1:0] index,
                                 logic [VALUE_W-1:0] value);
            result_t state;
            state.slot_start = 1'b0;
            if (kind == KIND_WRITE)
            begin
                if (index < NUM_CH)
                begin
                    channel_ticks[index] = value;
                end
            end
            else
            begin
                if (slot_left != 0)
                begin
                    slot_left--;
                end
                if (pulse_left != 0)
                begin
                    pulse_left--;
                end
                if (slot_left == 0)
                begin
                    if (next_slot < NUM_CH)
                    begin
                        slot_left = channel_ticks[next_slot];
                        next_slot++;
                    end
                    else
                    begin
                        slot_left = sync_ticks();
                        next_slot = 0;
                    end
                    pulse_left = pulse_width;
                    state.slot_start = 1'b1;
                end
            end
            state.ppm_level = (pulse_left != 0);
            state.slot_index = (next_slot == 0) ? SLOT_W'(NUM_CH) : SLOT_W'(next_slot - 1);
            pin_states_due.push_back(state);
        endfunction

        function int unsigned pending();
            return pin_states_due.size();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t, result %0d: %s", $time, results_seen, what);
            mismatches++;
        endtask

        task check_result(logic level, logic [SLOT_W-1:0] slot, logic start);
            result_t want;
            results_seen++;
            if (pin_states_due.size() == 0)
            begin
                report_mismatch("result with no item outstanding");
                return;
            end
            want = pin_states_due.pop_front();
            if (level !== want.ppm_level)
            begin
                report_mismatch($sformatf("ppm_level is %b, expected %b", level, want.ppm_level));
            end
            if (slot !== want.slot_index)
            begin
                report_mismatch($sformatf("slot_index is %0d, expected %0d",
                                          slot, want.slot_index));
            end
            if (start !== want.slot_start)
            begin
                report_mismatch($sformatf("slot_start is %b, expected %b",
                                          start, want.slot_start));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    ppmfg_item_if   item_bus ();
    ppmfg_result_if result_bus ();
    ppmfg_cfg_if    cfg_bus ();

    ppm_frame_predictor tracker;

    int unsigned rx_stall_pct;
    bit          hold_request;
    int unsigned quiet_cycles;

    ppm_frame_generator_unit #(
        .NUM_CHANNELS(NUM_CH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_item(item_bus),
        .out_result(result_bus),
        .cfg(cfg_bus)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: runs of ready or stall of random length, plus one long hold-off on request.
    initial
    begin
        int unsigned run_left;
        int unsigned hold_left;
        bit          level;
        result_bus.ready = 1'b0;
        run_left = 0;
        hold_left = 0;
        level = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(1, 8);
                    level = ($urandom_range(0, 99) >= rx_stall_pct);
                end
                run_left--;
                result_bus.ready <= level;
            end
        end
    end

    // Result checking and activity tracking for the watchdog.
    always @(posedge clk)
    begin
        if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            tracker.check_result(result_bus.ppm_level, result_bus.slot_index,
                                 result_bus.slot_start);
        end
        if ((result_bus.valid === 1'b1 && result_bus.ready === 1'b1) ||
            (item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
            (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
    end

    // Watchdog: too long without any transfer ends the run.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Offer one item and wait for its transfer.
    task automatic send_item(input logic kind, input logic [CH_INDEX_W-1:0] index,
                             input logic [VALUE_W-1:0] value);
        @(negedge clk);
        item_bus.valid <= 1'b1;
        item_bus.kind <= kind;
        item_bus.channel_index <= index;
        item_bus.channel_value <= value;
        do
        begin
            @(posedge clk);
        end
        while (item_bus.ready !== 1'b1);
        tracker.apply_item(kind, index, value);
    endtask

    task automatic tick();
        send_item(KIND_TICK, CH_INDEX_W'($urandom_range(0, 7)), VALUE_W'($urandom));
    endtask

    task automatic idle_items(input int unsigned cycles);
        if (cycles != 0)
        begin
            @(negedge clk);
            item_bus.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [VALUE_W-1:0] data);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data <= data;
        do
        begin
            @(posedge clk);
        end
        while (cfg_bus.ready !== 1'b1);
        tracker.set_register(index, data);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Stop offering items and wait until every result has come back.
    task automatic settle();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input logic [VALUE_W-1:0] frame, input logic [VALUE_W-1:0] pulse);
        settle();
        write_reg(CFG_FRAME_LENGTH, frame);
        write_reg(CFG_PULSE_WIDTH, pulse);
    endtask

    // Mostly ticks with short channel values so frames wrap often. A full-range value
    // goes only to the channel furthest from reload and is replaced a few items later.
    task automatic run_random(input int unsigned count, input int unsigned gap_max,
                              input bit with_hold);
        int unsigned           done_items;
        int unsigned           burst;
        int unsigned           pick;
        int                    restore_left;
        bit                    hold_pending;
        logic                  kind;
        logic [CH_INDEX_W-1:0] index;
        logic [CH_INDEX_W-1:0] restore_index;
        logic [VALUE_W-1:0]    value;
        done_items = 0;
        restore_left = -1;
        restore_index = '0;
        hold_pending = with_hold;
        while (done_items < count || restore_left >= 0)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                if (restore_left == 0)
                begin
                    kind = KIND_WRITE;
                    index = restore_index;
                    value = VALUE_W'($urandom_range(0, 8));
                    restore_left = -1;
                end
                else
                begin
                    if (restore_left > 0)
                    begin
                        restore_left--;
                    end
                    kind = ($urandom_range(0, 4) == 0) ? KIND_WRITE : KIND_TICK;
                    index = CH_INDEX_W'($urandom_range(0, NUM_CH - 1));
                    pick = $urandom_range(0, 99);
                    value = (pick < 75) ? VALUE_W'($urandom_range(0, 8))
                                        : VALUE_W'($urandom_range(0, 60));
                    if (kind == KIND_TICK)
                    begin
                        index = CH_INDEX_W'($urandom_range(0, 7));
                        value = VALUE_W'($urandom);
                    end
                    else if (pick >= 96 && restore_left < 0)
                    begin
                        index = (tracker.next_slot == 0) ? CH_INDEX_W'(NUM_CH - 1)
                                                         : CH_INDEX_W'(tracker.next_slot - 1);
                        value = VALUE_W'($urandom);
                        restore_index = index;
                        restore_left = $urandom_range(0, 3);
                    end
                    else if ($urandom_range(0, 19) == 0)
                    begin
                        index = CH_INDEX_W'($urandom_range(NUM_CH, 7));
                    end
                end
                send_item(kind, index, value);
                if (!(kind == KIND_WRITE && index >= NUM_CH))
                begin
                    done_items++;
                end
            end
            if (hold_pending && done_items >= count / 2)
            begin
                hold_request = 1'b1;
                hold_pending = 1'b0;
            end
            if (gap_max != 0)
            begin
                idle_items($urandom_range(0, gap_max));
            end
        end
    endtask

    task automatic run_phase(input logic [VALUE_W-1:0] frame, input logic [VALUE_W-1:0] pulse,
                             input int unsigned stall_pct, input int unsigned gap_max,
                             input int unsigned count, input bit with_hold);
        set_frame(frame, pulse);
        rx_stall_pct = stall_pct;
        run_random(count, gap_max, with_hold);
    endtask

    // Run the channel slots under a full-scale pulse, then load large channel values
    // during the last channel slot so the sync space is sized from a wide channel sum
    // against a full-scale frame. The channels go back to short values inside the sync
    // space, before any of them is reloaded.
    task automatic run_full_scale(input logic [VALUE_W-1:0] ch_value,
                                  input logic [VALUE_W-1:0] pulse);
        set_frame(16'hFFFF, 16'hFFFF);
        rx_stall_pct = 10;
        while (tracker.next_slot != NUM_CH)
        begin
            tick();
        end
        for (int k = 0; k < NUM_CH; k++)
        begin
            send_item(KIND_WRITE, CH_INDEX_W'(k), ch_value);
        end
        set_frame(16'hFFFF, pulse);
        while (tracker.next_slot != 0)
        begin
            tick();
        end
        for (int k = 0; k < NUM_CH; k++)
        begin
            send_item(KIND_WRITE, CH_INDEX_W'(k), VALUE_W'($urandom_range(0, 8)));
        end
        while (tracker.next_slot == 0)
        begin
            tick();
        end
    endtask

    // Main sequence.
    initial
    begin
        tracker = new();
        rx_stall_pct = 0;
        hold_request = 1'b0;
        quiet_cycles = 0;
        item_bus.valid = 1'b0;
        item_bus.kind = KIND_TICK;
        item_bus.channel_index = '0;
        item_bus.channel_value = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_FRAME_LENGTH;
        cfg_bus.data = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: state before the first tick, ignored channels, and
        // zero-length slots under a pulse longer than the slot.
        send_item(KIND_WRITE, 3'd0, 16'd0);
        send_item(KIND_WRITE, 3'd7, 16'hFFFF);
        send_item(KIND_WRITE, 3'd6, 16'hAAAA);
        send_item(KIND_WRITE, 3'd5, 16'hFFFF);
        tick();
        tick();
        send_item(KIND_WRITE, 3'd5, 16'd1);
        tick();
        tick();

        // Channel sum above the frame: sync falls back to one pulse width.
        set_frame(16'd10, 16'd4);
        tick();
        tick();
        send_item(KIND_WRITE, 3'd0, 16'd5);
        send_item(KIND_WRITE, 3'd1, 16'd2);
        send_item(KIND_WRITE, 3'd2, 16'd3);
        send_item(KIND_WRITE, 3'd4, 16'd1);
        repeat (7) tick();

        // Random traffic under a range of frame settings and handshake pressure.
        run_phase(16'd120, 16'd2, 0, 0, 200, 1'b0);
        run_phase(16'd0, 16'd0, 30, 4, 150, 1'b0);
        run_phase(16'd60, 16'd1, 50, 3, 250, 1'b1);
        run_phase(16'd300, 16'd9, 20, 8, 200, 1'b0);
        run_phase(16'd0, 16'd1, 70, 2, 150, 1'b0);
        run_phase(16'd200, 16'd40, 10, 0, 200, 1'b0);
        run_phase(16'd25, 16'd5, 40, 6, 200, 1'b1);

        // Full-scale frame: a channel sum far above it, then one just below it.
        run_full_scale(16'hFFFF, 16'd3);
        run_full_scale(16'h2AA0, 16'd40);

        run_phase(16'd50, 16'd3, 60, 5, 150, 1'b0);

        settle();
        if (tracker.mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
